@@ rtl/ccd_pixel_noise_error_init_macros.svh @@
// Assertion macros for the pixel error block.
// Define ASSERT_OFF to compile every check away.
`ifndef CCD_PIXEL_NOISE_ERROR_INIT_MACROS_SVH
`define CCD_PIXEL_NOISE_ERROR_INIT_MACROS_SVH

`ifndef ASSERT_OFF

// a implies b in the same cycle
`define CPNE_ASSERT_IMPL(label, clk, rst_n, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error(msg);

// a implies b in the next cycle
`define CPNE_ASSERT_NEXT(label, clk, rst_n, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error(msg);

`else

`define CPNE_ASSERT_IMPL(label, clk, rst_n, a, b, msg)
`define CPNE_ASSERT_NEXT(label, clk, rst_n, a, b, msg)

`endif

`endif

@@ rtl/cpne_pkg.sv @@
`timescale 1ns / 1ps

package cpne_pkg;

  // image geometry, boundaries above this are clipped to it
  localparam int unsigned IMAGE_DIM = 4096;
  localparam int unsigned BND_W     = 13;
  localparam logic [BND_W-1:0] IMAGE_DIM_C = BND_W'(IMAGE_DIM);

  // field widths
  localparam int unsigned PIX_W   = 12;
  localparam int unsigned SCI_W   = 32;
  localparam int unsigned ERR_W   = 24;
  localparam int unsigned NOISE_W = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // root datapath: radicand < 2^49, padded to an even width
  localparam int unsigned RAD_W  = 50;
  localparam int unsigned ROOT_W = RAD_W / 2;
  localparam int unsigned REM_W  = ROOT_W + 1;
  localparam int unsigned CUR_W  = REM_W + 2;

  localparam logic [ERR_W-1:0]  OUT_MAX = {ERR_W{1'b1}};
  localparam logic [ROOT_W-1:0] ONE_Q8  = ROOT_W'(256);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DETECTOR_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BIAS_EXPOSURE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AMP_COL_BND   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_AMP_ROW_BND   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NOISE_A       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_NOISE_B       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_NOISE_C       = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_NOISE_D       = 3'd7;

  // live configuration
  typedef struct packed {
    logic               mama;
    logic               bias;
    logic [BND_W-1:0]   col_bnd;
    logic [BND_W-1:0]   row_bnd;
    logic [NOISE_W-1:0] noise_a;
    logic [NOISE_W-1:0] noise_b;
    logic [NOISE_W-1:0] noise_c;
    logic [NOISE_W-1:0] noise_d;
  } cfg_t;

  // per-request side info carried alongside the radicand
  typedef struct packed {
    logic               mama;
    logic               bypass;
    logic [NOISE_W-1:0] bypass_val;
    logic               missing;
    logic               neg;
  } side_t;

endpackage

@@ rtl/cpne_if.sv @@
`timescale 1ns / 1ps

// pixel request channel
interface cpne_in_if;
  import cpne_pkg::*;
  logic               valid;
  logic               ready;
  logic [PIX_W-1:0]   pixel_col;
  logic [PIX_W-1:0]   pixel_row;
  logic signed [SCI_W-1:0] sci_value;
  logic [ERR_W-1:0]   err_value;

  modport source (output valid, pixel_col, pixel_row, sci_value, err_value, input ready);
  modport sink   (input valid, pixel_col, pixel_row, sci_value, err_value, output ready);
endinterface

// result channel
interface cpne_out_if;
  import cpne_pkg::*;
  logic             valid;
  logic             ready;
  logic [ERR_W-1:0] err_out;
  logic             missing_noise;
  logic             negative_sci;
  logic             saturated;

  modport source (output valid, err_out, missing_noise, negative_sci, saturated,
                  input ready);
  modport sink   (input valid, err_out, missing_noise, negative_sci, saturated,
                  output ready);
endinterface

// register write channel
interface cpne_cfg_if;
  import cpne_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/cpne_cfg_regs.sv @@
`timescale 1ns / 1ps

module cpne_cfg_regs
  import cpne_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  cpne_cfg_if.sink   cfg_if,
  output cfg_t       cfg
);

  cfg_t cfg_r;

  assign cfg_if.ready = 1'b1;
  assign cfg          = cfg_r;

  // register writes, always accepted
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_if.valid) begin
      unique case (cfg_if.index)
        REG_DETECTOR_MODE: cfg_r.mama    <= cfg_if.data[0];
        REG_BIAS_EXPOSURE: cfg_r.bias    <= cfg_if.data[0];
        REG_AMP_COL_BND:   cfg_r.col_bnd <= cfg_if.data[BND_W-1:0];
        REG_AMP_ROW_BND:   cfg_r.row_bnd <= cfg_if.data[BND_W-1:0];
        REG_NOISE_A:       cfg_r.noise_a <= cfg_if.data[NOISE_W-1:0];
        REG_NOISE_B:       cfg_r.noise_b <= cfg_if.data[NOISE_W-1:0];
        REG_NOISE_C:       cfg_r.noise_c <= cfg_if.data[NOISE_W-1:0];
        REG_NOISE_D:       cfg_r.noise_d <= cfg_if.data[NOISE_W-1:0];
        default:           cfg_r <= cfg_r;
      endcase
    end
  end

endmodule

@@ rtl/cpne_front.sv @@
`timescale 1ns / 1ps

// Three stages: region/mode decode, squares, radicand sum.
module cpne_front
  import cpne_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  input  logic               up_valid,
  output logic               up_ready,
  input  logic [PIX_W-1:0]   pixel_col,
  input  logic [PIX_W-1:0]   pixel_row,
  input  logic [SCI_W-1:0]   sci_value,
  input  logic [ERR_W-1:0]   err_value,
  output logic               dn_valid,
  input  logic               dn_ready,
  output logic [RAD_W-1:0]   dn_rad,
  output side_t              dn_side
);

  localparam int unsigned RN2_W  = 2 * NOISE_W;
  localparam int unsigned ERR2_W = 2 * ERR_W;

  logic [BND_W-1:0]   col_lim, row_lim;
  logic               upper, right, sci_neg;
  logic [NOISE_W-1:0] rn;
  logic [SCI_W-1:0]   sci_mag;
  side_t              side_s1;

  logic               v1_r, v2_r, v3_r;
  logic               en1, en2, en3;
  logic [SCI_W-1:0]   base1_r, base2_r;
  logic [NOISE_W-1:0] rn1_r;
  logic [ERR_W-1:0]   err1_r;
  logic [RN2_W-1:0]   rn2_r;
  logic [ERR2_W-1:0]  err2_r;
  logic [RAD_W-1:0]   rad3_r;
  side_t              side1_r, side2_r, side3_r;

  // stall chain: a stage moves when empty or when the next one moves
  assign en3      = !v3_r || dn_ready;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign up_ready = en1;

  // amplifier region and read noise
  always_comb begin
    col_lim = (cfg.col_bnd > IMAGE_DIM_C) ? IMAGE_DIM_C : cfg.col_bnd;
    row_lim = (cfg.row_bnd > IMAGE_DIM_C) ? IMAGE_DIM_C : cfg.row_bnd;
    upper   = {1'b0, pixel_row} >= row_lim;
    right   = {1'b0, pixel_col} >= col_lim;
    unique case ({upper, right})
      2'b11:   rn = cfg.noise_b;
      2'b10:   rn = cfg.noise_a;
      2'b01:   rn = cfg.noise_d;
      default: rn = cfg.noise_c;
    endcase
    sci_neg = sci_value[SCI_W-1];
    sci_mag = sci_neg ? (SCI_W'(0) - sci_value) : sci_value;

    side_s1.mama       = cfg.mama;
    side_s1.missing    = !cfg.mama && (rn == '0);
    side_s1.bypass     = !cfg.mama && ((rn == '0) || cfg.bias);
    side_s1.bypass_val = (rn == '0) ? '0 : rn;
    side_s1.neg        = cfg.mama && sci_neg;
  end

  // stage 1: decoded operands; MAMA uses |sci| alone
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en1) begin
      v1_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      side1_r <= side_s1;
      rn1_r   <= cfg.mama ? '0 : rn;
      err1_r  <= cfg.mama ? '0 : err_value;
      if (cfg.mama) begin
        base1_r <= sci_mag;
      end else begin
        base1_r <= sci_neg ? '0 : sci_value;
      end
    end
  end

  // stage 2: squares
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      side2_r <= side1_r;
      base2_r <= base1_r;
      rn2_r   <= rn1_r * rn1_r;
      err2_r  <= err1_r * err1_r;
    end
  end

  // stage 3: radicand in Q.16
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en3) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      side3_r <= side2_r;
      rad3_r  <= RAD_W'({base2_r, 8'h00}) + RAD_W'(rn2_r) + RAD_W'(err2_r);
    end
  end

  assign dn_valid = v3_r;
  assign dn_rad   = rad3_r;
  assign dn_side  = side3_r;

endmodule

@@ rtl/cpne_sqrt.sv @@
`timescale 1ns / 1ps

// Integer square root, one result bit per stage, truncated toward zero.
module cpne_sqrt
  import cpne_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              up_valid,
  output logic              up_ready,
  input  logic [RAD_W-1:0]  up_rad,
  input  side_t             up_side,
  output logic              dn_valid,
  input  logic              dn_ready,
  output logic [ROOT_W-1:0] dn_root,
  output side_t             dn_side
);

  localparam int unsigned N = ROOT_W;

  logic              v_s    [0:N];
  logic [RAD_W-1:0]  rad_s  [0:N];
  logic [REM_W-1:0]  rem_s  [0:N];
  logic [ROOT_W-1:0] q_s    [0:N];
  side_t             side_s [0:N];
  logic              en     [0:N];

  logic              v_r    [1:N];
  logic [RAD_W-1:0]  rad_r  [1:N];
  logic [REM_W-1:0]  rem_r  [1:N];
  logic [ROOT_W-1:0] q_r    [1:N];
  side_t             side_r [1:N];

  assign v_s[0]    = up_valid;
  assign rad_s[0]  = up_rad;
  assign rem_s[0]  = '0;
  assign q_s[0]    = '0;
  assign side_s[0] = up_side;
  assign en[N]     = dn_ready;
  assign up_ready  = en[0];

  genvar i;
  generate
    for (i = 0; i < N; i++) begin : g_stage
      logic [CUR_W-1:0] cur, trial, diff;
      logic             take;

      // one restoring step: bring down two radicand bits, try q*4+1
      always_comb begin
        cur   = {rem_s[i], rad_s[i][RAD_W-1 -: 2]};
        trial = CUR_W'({q_s[i], 2'b01});
        take  = cur >= trial;
        diff  = cur - trial;
      end

      assign en[i] = !v_r[i+1] || en[i+1];

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[i+1] <= 1'b0;
        end else if (en[i]) begin
          v_r[i+1] <= v_s[i];
        end
      end

      always_ff @(posedge clk) begin
        if (en[i]) begin
          rad_r[i+1]  <= {rad_s[i][RAD_W-3:0], 2'b00};
          rem_r[i+1]  <= take ? diff[REM_W-1:0] : cur[REM_W-1:0];
          q_r[i+1]    <= {q_s[i][ROOT_W-2:0], take};
          side_r[i+1] <= side_s[i];
        end
      end

      assign v_s[i+1]    = v_r[i+1];
      assign rad_s[i+1]  = rad_r[i+1];
      assign rem_s[i+1]  = rem_r[i+1];
      assign q_s[i+1]    = q_r[i+1];
      assign side_s[i+1] = side_r[i+1];
    end
  endgenerate

  assign dn_valid = v_s[N];
  assign dn_root  = q_s[N];
  assign dn_side  = side_s[N];

endmodule

@@ rtl/ccd_pixel_noise_error_init.sv @@
`timescale 1ns / 1ps
// From request accept to result valid: 3 front stages, 25 square-root
// stages at one root bit each, and 1 output register.
// Throughput: one pixel per cycle when not stalled; every root pipeline
// stage is a 28-bit compare/subtract, and stalls hold each stage in place.
// Reset (rst_n low, synchronous): valid bits and configuration registers go
// to 0; pipeline data registers keep their contents.
`include "ccd_pixel_noise_error_init_macros.svh"

module ccd_pixel_noise_error_init
  import cpne_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  cpne_in_if.sink     in_if,
  cpne_out_if.source  out_if,
  cpne_cfg_if.sink    cfg_if
);

  cfg_t              cfg;
  logic              fr_valid, fr_ready;
  logic [RAD_W-1:0]  fr_rad;
  side_t             fr_side;
  logic              sq_valid, sq_ready;
  logic [ROOT_W-1:0] sq_root;
  side_t             sq_side;

  logic              out_valid_r;
  logic [ERR_W-1:0]  err_out_r, err_nxt;
  logic              missing_r, neg_r, sat_r, sat_nxt;

  cpne_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_if (cfg_if),
    .cfg    (cfg)
  );

  cpne_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .up_valid  (in_if.valid),
    .up_ready  (in_if.ready),
    .pixel_col (in_if.pixel_col),
    .pixel_row (in_if.pixel_row),
    .sci_value (in_if.sci_value),
    .err_value (in_if.err_value),
    .dn_valid  (fr_valid),
    .dn_ready  (fr_ready),
    .dn_rad    (fr_rad),
    .dn_side   (fr_side)
  );

  cpne_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (fr_valid),
    .up_ready (fr_ready),
    .up_rad   (fr_rad),
    .up_side  (fr_side),
    .dn_valid (sq_valid),
    .dn_ready (sq_ready),
    .dn_root  (sq_root),
    .dn_side  (sq_side)
  );

  // result formatting: bypass value, MAMA floor of one, CCD saturation
  always_comb begin
    sat_nxt = 1'b0;
    if (sq_side.bypass) begin
      err_nxt = ERR_W'(sq_side.bypass_val);
    end else if (sq_side.mama) begin
      err_nxt = (sq_root > ONE_Q8) ? sq_root[ERR_W-1:0] : ONE_Q8[ERR_W-1:0];
    end else if (sq_root[ROOT_W-1]) begin
      err_nxt = OUT_MAX;
      sat_nxt = 1'b1;
    end else begin
      err_nxt = sq_root[ERR_W-1:0];
    end
  end

  assign sq_ready = !out_valid_r || out_if.ready;

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (sq_ready) begin
      out_valid_r <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sq_ready) begin
      err_out_r <= err_nxt;
      missing_r <= sq_side.missing;
      neg_r     <= sq_side.neg;
      sat_r     <= sat_nxt;
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.err_out       = err_out_r;
  assign out_if.missing_noise = missing_r;
  assign out_if.negative_sci  = neg_r;
  assign out_if.saturated     = sat_r;

  // result consistency
  `CPNE_ASSERT_IMPL(a_sat_max, clk, rst_n, out_valid_r && sat_r, err_out_r == OUT_MAX, "saturated result not at maximum")
  `CPNE_ASSERT_IMPL(a_missing_zero, clk, rst_n, out_valid_r && missing_r, (err_out_r == '0) && !sat_r && !neg_r, "missing noise result not zero")
  `CPNE_ASSERT_IMPL(a_neg_mama, clk, rst_n, out_valid_r && neg_r, !missing_r && !sat_r && (err_out_r >= ONE_Q8[ERR_W-1:0]), "negative flag outside counting mode")
  `CPNE_ASSERT_NEXT(a_out_from_root, clk, rst_n, sq_ready && !sq_valid, !out_valid_r, "result without root stage data")

endmodule
